>>> design/axis_angle_to_rotation_matrix_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the axis-angle to rotation matrix core
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_CORE_DEFINES_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_CORE_DEFINES_SVH

// Same-cycle implication.
`define AARM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AARM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/aarm_pkg.sv
// ---------------------------------------------------------------------------
// aarm_pkg
// Shared types, fixed-point constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aarm_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 14;
  localparam int ATAN_ENTRIES     = 24;
  localparam int SQRT_STEPS       = 32;
  localparam int OUT_FRAC         = 14;
  localparam int OUT_ONE          = 16384;

  // Q30 angle datapath width
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_GAIN    = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               axis_zero;
  } out_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/aarm_cordic_cell.sv
// ---------------------------------------------------------------------------
// aarm_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aarm_cordic_cell import aarm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [ZW-1:0] x_i,
  input  logic signed [ZW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 flip_i,
  output logic signed [ZW-1:0] x_o,
  output logic signed [ZW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic                 flip_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q30(IDX);

  logic signed [ZW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, dx, dy;
  logic                 flip_r;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_comb begin
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      flip_r <= flip_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign flip_o = flip_r;

endmodule

>>> design/aarm_sqrt_cell.sv
// ---------------------------------------------------------------------------
// aarm_sqrt_cell
// One digit of a restoring square root of (sum * 2^32), registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aarm_sqrt_cell #(
  parameter int IDX = 31,
  parameter int RW  = 36
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   sum_i,
  input  logic [RW-1:0] rem_i,
  input  logic [31:0]   root_i,
  output logic [31:0]   sum_o,
  output logic [RW-1:0] rem_o,
  output logic [31:0]   root_o
);

  logic [1:0]    pair;
  logic [RW-1:0] rem4, trial, rem_nxt, rem_r;
  logic [31:0]   root_nxt, root_r, sum_r;

  // The low 32 radicand bits are zero.
  if (IDX >= 16) begin : g_hi
    assign pair = sum_i[2*IDX-31 -: 2];
  end else begin : g_lo
    assign pair = 2'b00;
  end

  assign rem4  = {rem_i[RW-3:0], pair};
  assign trial = {{(RW-34){1'b0}}, root_i, 2'b01};

  always_comb begin
    if (rem4 >= trial) begin
      rem_nxt  = rem4 - trial;
      root_nxt = {root_i[30:0], 1'b1};
    end else begin
      rem_nxt  = rem4;
      root_nxt = {root_i[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      sum_r  <= sum_i;
    end
  end

  assign sum_o  = sum_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

>>> design/aarm_div_cell.sv
// ---------------------------------------------------------------------------
// aarm_div_cell
// One quotient bit of three restoring divisions by a shared root.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aarm_div_cell #(
  parameter int K  = 0,
  parameter int NW = 47,
  parameter int QW = 15
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          root_i,
  input  logic [2:0][NW-1:0]   r_i,
  input  logic [2:0][QW-1:0]   q_i,
  output logic [31:0]          root_o,
  output logic [2:0][NW-1:0]   r_o,
  output logic [2:0][QW-1:0]   q_o
);

  logic [NW-1:0]          dvs;
  logic [2:0][NW-1:0]     r_nxt, r_r;
  logic [2:0][QW-1:0]     q_nxt, q_r;
  logic [31:0]            root_r;

  assign dvs = {{(NW-32){1'b0}}, root_i} << K;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (r_i[j] >= dvs) begin
        r_nxt[j] = r_i[j] - dvs;
        q_nxt[j] = {q_i[j][QW-2:0], 1'b1};
      end else begin
        r_nxt[j] = r_i[j];
        q_nxt[j] = {q_i[j][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= r_nxt;
      q_r    <= q_nxt;
      root_r <= root_i;
    end
  end

  assign root_o = root_r;
  assign r_o    = r_r;
  assign q_o    = q_r;

endmodule

>>> design/axis_angle_to_rotation_matrix_core.sv
// ---------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_core
// Rodrigues rotation: angle and unnormalised axis in, 3x3 matrix in Q1.14 out.
// ---------------------------------------------------------------------------
//
//   channel | ports                          | word
//   --------+--------------------------------+--------------------------------
//   input   | in_valid  in_ready  in_data    | angle Q3.13, axis x/y/z
//   result  | out_valid out_ready out_data   | m00..m22 Q1.14, axis_zero
//
// One word is accepted per cycle while the skid is empty. A word passes two
// input stages, 32 square-root cells, FRAC_BITS+1 divider cells, four matrix
// stages and the output register; the CORDIC row runs alongside the root.
// Reset (rst_n low, synchronous) empties the pipeline and the output side.
// A held result parks in a skid register; the pipeline stalls as a whole
// only while the skid is occupied, so in_ready is a register output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_angle_to_rotation_matrix_core import aarm_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int FB  = FRAC_BITS;
  localparam int CS  = CORDIC_STEPS;
  localparam int QW  = FB + 1;          // quotient never exceeds 2^FB
  localparam int NW  = FB + 33;         // dividend width
  localparam int VW  = FB + 3;          // signed datapath value width
  localparam int EW  = VW + 1;          // entry sum width
  localparam int RW  = 36;              // square-root remainder width
  localparam int DL  = 33 + QW - CS;    // cos/sin alignment depth
  localparam int VL  = 38 + QW;         // pipeline stages carrying a valid
  localparam int SHC = 30 - FB;
  localparam int OSR = (FB > OUT_FRAC) ? FB - OUT_FRAC : 0;
  localparam int OSL = (FB < OUT_FRAC) ? OUT_FRAC - FB : 0;

  localparam logic signed [ZW-1:0]   CRND = (SHC > 0) ? (ZW'(1) <<< (SHC - 1)) : '0;
  localparam logic signed [2*VW-1:0] FRND = (2*VW)'(1) <<< (FB - 1);
  localparam logic signed [EW+3:0]   ORND = (OSR > 0) ? ((EW+4)'(1) <<< (OSR - 1)) : '0;
  localparam logic signed [EW+3:0]   ONE_W = (EW+4)'(OUT_ONE);
  localparam logic signed [VW-1:0]   ONE_V = VW'(1) <<< FB;
  localparam logic [QW-1:0]          ONE_Q = QW'(1) << FB;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } dside_t;

  typedef struct packed {
    logic signed [VW-1:0] c;
    logic signed [VW-1:0] s;
    logic signed [VW-1:0] ic;
  } cs_t;

  // Round a Q(2FB) product half up back to Q(FB).
  function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = a * b;
    p = (p + FRND) >>> FB;
    return p[VW-1:0];
  endfunction

  // Rescale to Q14, round half up, saturate to plus or minus one.
  function automatic logic signed [15:0] to_out(input logic signed [EW-1:0] v);
    logic signed [EW+3:0] w;
    w = {{4{v[EW-1]}}, v};
    w = ((w + ORND) >>> OSR) <<< OSL;
    if (w > ONE_W) w = ONE_W;
    if (w < -ONE_W) w = -ONE_W;
    return w[15:0];
  endfunction

  logic en;
  logic [VL-1:0] v_r;

  // ---- stage 0: squares, angle reduction, signs ----
  logic [2:0][15:0]     ax, mag_nxt;
  logic [2:0]           neg_nxt;
  logic signed [ZW-1:0] z_in, z_nxt;
  logic                 flip_nxt;
  logic [2:0][30:0]     sq_r;
  side_t                s0_r, s1_r;
  logic signed [ZW-1:0] z0_r;
  logic                 flip0_r;
  logic [31:0]          sum_r;

  // lane 0 is x, lane 2 is z
  assign ax = {in_data.axis_z, in_data.axis_y, in_data.axis_x};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      neg_nxt[j] = ax[j][15];
      mag_nxt[j] = ax[j][15] ? (~ax[j] + 16'd1) : ax[j];
    end
    z_in = {in_data.angle[15], in_data.angle, 17'b0};
    if (z_in > Q30_HALF_PI) begin
      z_nxt    = z_in - Q30_PI;
      flip_nxt = 1'b1;
    end else if (z_in < -Q30_HALF_PI) begin
      z_nxt    = z_in + Q30_PI;
      flip_nxt = 1'b1;
    end else begin
      z_nxt    = z_in;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq_r[j] <= 31'({16'd0, mag_nxt[j]} * {16'd0, mag_nxt[j]});
      end
      s0_r.mag  <= mag_nxt;
      s0_r.neg  <= neg_nxt;
      s0_r.zero <= (ax == '0);
      z0_r      <= z_nxt;
      flip0_r   <= flip_nxt;
      // stage 1: sum of squares
      sum_r <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
      s1_r  <= s0_r;
    end
  end

  // ---- CORDIC row ----
  logic signed [ZW-1:0] cx_a [0:CS];
  logic signed [ZW-1:0] cy_a [0:CS];
  logic signed [ZW-1:0] cz_a [0:CS];
  logic                 cf_a [0:CS];

  assign cx_a[0] = Q30_GAIN;
  assign cy_a[0] = '0;
  assign cz_a[0] = z0_r;
  assign cf_a[0] = flip0_r;

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    aarm_cordic_cell #(.IDX(k)) u_cell (
      .clk    (clk),
      .en     (en),
      .x_i    (cx_a[k]),
      .y_i    (cy_a[k]),
      .z_i    (cz_a[k]),
      .flip_i (cf_a[k]),
      .x_o    (cx_a[k+1]),
      .y_o    (cy_a[k+1]),
      .z_o    (cz_a[k+1]),
      .flip_o (cf_a[k+1])
    );
  end

  // Negate on flip, round to Q(FB), then delay to meet the quotients.
  logic signed [ZW-1:0] xf, yf, cr, sr;
  cs_t                  cs_nxt;
  cs_t                  cs_r [DL];

  always_comb begin
    xf = cf_a[CS] ? -cx_a[CS] : cx_a[CS];
    yf = cf_a[CS] ? -cy_a[CS] : cy_a[CS];
    cr = (xf + CRND) >>> SHC;
    sr = (yf + CRND) >>> SHC;
    cs_nxt.c  = cr[VW-1:0];
    cs_nxt.s  = sr[VW-1:0];
    cs_nxt.ic = ONE_V - cr[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r[0] <= cs_nxt;
      for (int d = 1; d < DL; d++) begin
        cs_r[d] <= cs_r[d-1];
      end
    end
  end

  // ---- square-root row ----
  logic [31:0]   sum_a  [0:SQRT_STEPS];
  logic [RW-1:0] rem_a  [0:SQRT_STEPS];
  logic [31:0]   root_a [0:SQRT_STEPS];
  side_t         sd_r   [SQRT_STEPS];

  assign sum_a[0]  = sum_r;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    aarm_sqrt_cell #(.IDX(SQRT_STEPS - 1 - k), .RW(RW)) u_cell (
      .clk    (clk),
      .en     (en),
      .sum_i  (sum_a[k]),
      .rem_i  (rem_a[k]),
      .root_i (root_a[k]),
      .sum_o  (sum_a[k+1]),
      .rem_o  (rem_a[k+1]),
      .root_o (root_a[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= s1_r;
      for (int d = 1; d < SQRT_STEPS; d++) begin
        sd_r[d] <= sd_r[d-1];
      end
    end
  end

  // ---- divider row: n = |a| * 2^(FB+16) / root, rounded ----
  logic [31:0]        droot_a [0:QW];
  logic [2:0][NW-1:0] dr_a    [0:QW];
  logic [2:0][QW-1:0] dq_a    [0:QW];
  dside_t             dsd_r   [QW];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dr_a[0][j] = {1'b0, sd_r[SQRT_STEPS-1].mag[j], (FB+16)'(0)}
                   + {(NW-31)'(0), root_a[SQRT_STEPS][31:1]};
    end
  end

  assign droot_a[0] = root_a[SQRT_STEPS];
  assign dq_a[0]    = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    aarm_div_cell #(.K(QW - 1 - k), .NW(NW), .QW(QW)) u_cell (
      .clk    (clk),
      .en     (en),
      .root_i (droot_a[k]),
      .r_i    (dr_a[k]),
      .q_i    (dq_a[k]),
      .root_o (droot_a[k+1]),
      .r_o    (dr_a[k+1]),
      .q_o    (dq_a[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsd_r[0].neg  <= sd_r[SQRT_STEPS-1].neg;
      dsd_r[0].zero <= sd_r[SQRT_STEPS-1].zero;
      for (int d = 1; d < QW; d++) begin
        dsd_r[d] <= dsd_r[d-1];
      end
    end
  end

  // ---- matrix stages ----
  logic signed [VW-1:0] n_nxt [3];
  logic [QW-1:0]        qc;
  cs_t                  csq;

  assign csq = cs_r[DL-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qc       = (dq_a[QW][j] > ONE_Q) ? ONE_Q : dq_a[QW][j];
      n_nxt[j] = dsd_r[QW-1].neg[j] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    end
  end

  // lane order: x, y, z; pairs xx yy zz xy yz zx
  logic signed [VW-1:0] nn_r [6];
  logic signed [VW-1:0] ns1_r [3];
  logic signed [VW-1:0] ns2_r [3];
  logic signed [VW-1:0] t_r  [6];
  logic signed [VW-1:0] c1_r, ic1_r, c2_r;
  logic signed [EW-1:0] e_r  [9];
  logic                 zr1_r, zr2_r, zr3_r;
  out_t                 pd_r, pd_nxt;

  function automatic logic signed [EW-1:0] ext(input logic signed [VW-1:0] a);
    return {a[VW-1], a};
  endfunction

  always_comb begin
    if (zr3_r) begin
      pd_nxt     = '0;
      pd_nxt.m00 = 16'(OUT_ONE);
      pd_nxt.m11 = 16'(OUT_ONE);
      pd_nxt.m22 = 16'(OUT_ONE);
      pd_nxt.axis_zero = 1'b1;
    end else begin
      pd_nxt.m00 = to_out(e_r[0]);
      pd_nxt.m01 = to_out(e_r[1]);
      pd_nxt.m02 = to_out(e_r[2]);
      pd_nxt.m10 = to_out(e_r[3]);
      pd_nxt.m11 = to_out(e_r[4]);
      pd_nxt.m12 = to_out(e_r[5]);
      pd_nxt.m20 = to_out(e_r[6]);
      pd_nxt.m21 = to_out(e_r[7]);
      pd_nxt.m22 = to_out(e_r[8]);
      pd_nxt.axis_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // M1: axis products and axis times sine
      nn_r[0] <= fmul(n_nxt[0], n_nxt[0]);
      nn_r[1] <= fmul(n_nxt[1], n_nxt[1]);
      nn_r[2] <= fmul(n_nxt[2], n_nxt[2]);
      nn_r[3] <= fmul(n_nxt[0], n_nxt[1]);
      nn_r[4] <= fmul(n_nxt[1], n_nxt[2]);
      nn_r[5] <= fmul(n_nxt[2], n_nxt[0]);
      for (int j = 0; j < 3; j++) begin
        ns1_r[j] <= fmul(n_nxt[j], csq.s);
      end
      c1_r  <= csq.c;
      ic1_r <= csq.ic;
      zr1_r <= dsd_r[QW-1].zero;
      // M2: scale by one minus cosine
      for (int j = 0; j < 6; j++) begin
        t_r[j] <= fmul(nn_r[j], ic1_r);
      end
      ns2_r <= ns1_r;
      c2_r  <= c1_r;
      zr2_r <= zr1_r;
      // M3: Rodrigues sums
      e_r[0] <= ext(t_r[0]) + ext(c2_r);
      e_r[1] <= ext(t_r[3]) - ext(ns2_r[2]);
      e_r[2] <= ext(t_r[5]) + ext(ns2_r[1]);
      e_r[3] <= ext(t_r[3]) + ext(ns2_r[2]);
      e_r[4] <= ext(t_r[1]) + ext(c2_r);
      e_r[5] <= ext(t_r[4]) - ext(ns2_r[0]);
      e_r[6] <= ext(t_r[5]) - ext(ns2_r[1]);
      e_r[7] <= ext(t_r[4]) + ext(ns2_r[0]);
      e_r[8] <= ext(t_r[2]) + ext(c2_r);
      zr3_r  <= zr2_r;
      // M4: rescale, saturate, override for a zero axis
      pd_r <= pd_nxt;
    end
  end

  // ---- valid line ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VL-2:0], in_valid};
    end
  end

  // ---- output register and skid ----
  logic out_valid_r, skid_valid_r, take;
  out_t out_r, skid_r;

  assign take = out_ready || !out_valid_r;
  assign en   = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (v_r[VL-1]) begin
      if (take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (v_r[VL-1]) begin
      if (take) begin
        out_r <= pd_r;
      end else begin
        skid_r <= pd_r;
      end
    end
  end

  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/aarm_checker.sv
// ---------------------------------------------------------------------------
// aarm_checker
// Port-level checks on the rotation matrix core, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "axis_angle_to_rotation_matrix_core_defines.svh"

module aarm_checker import aarm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `AARM_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "input word changed while waiting")
  `AARM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `AARM_ASSERT_NOW(a_stall_has_word, !in_ready, out_valid, "input stalled with no result word waiting")
  `AARM_ASSERT_NOW(a_zero_identity, out_valid && out_data.axis_zero, out_data.m00 == 16'sd16384 && out_data.m11 == 16'sd16384 && out_data.m22 == 16'sd16384 && out_data.m01 == 16'sd0 && out_data.m02 == 16'sd0 && out_data.m10 == 16'sd0 && out_data.m12 == 16'sd0 && out_data.m20 == 16'sd0 && out_data.m21 == 16'sd0, "zero axis without identity")
  `AARM_ASSERT_NOW(a_diag_range, out_valid, out_data.m00 <= 16'sd16384 && out_data.m00 >= -16'sd16384 && out_data.m11 <= 16'sd16384 && out_data.m11 >= -16'sd16384 && out_data.m22 <= 16'sd16384 && out_data.m22 >= -16'sd16384, "diagonal entry outside unit range")

endmodule

bind axis_angle_to_rotation_matrix_core aarm_checker u_aarm_checker (.*);
